[rtl/pps_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg - preemptive priority scheduler shared definitions
// Table sizing, field widths, request kind codes and controller interface.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_TASKS);
  localparam int CNT_W   = $clog2(MAX_TASKS + 1);
  localparam int TCNT_W  = 5;
  localparam int BYTE_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int TOUT_W  = 16;

  localparam logic [TCNT_W-1:0]    TASK_CNT_RST = TCNT_W'(16);
  localparam logic [TIME_BITS-1:0] TIME_MAX     = '1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic commit;
  } pps_cmd_t;

  typedef struct packed {
    logic scan_end;
  } pps_sts_t;

endpackage
`default_nettype wire

[rtl/pps_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pps_ctrl - scheduler controller
// Accepts requests, sequences the slot scan, commit and result hand-off.
// ----------------------------------------------------------------------------
module pps_ctrl
  import pps_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     kind_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire pps_sts_t sts_i,
  output pps_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_STEP) begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[rtl/pps_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pps_datapath - scheduler task table and selection datapath
// Holds the task table and time, scans one slot per cycle, commits one unit.
// ----------------------------------------------------------------------------
module pps_datapath
  import pps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TCNT_W-1:0] cfg_wdata_i,
  input  wire pps_cmd_t          cmd_i,
  output pps_sts_t               sts_o,
  input  wire logic [SLOT_W-1:0] slot_i,
  input  wire logic [BYTE_W-1:0] arrival_time_i,
  input  wire logic [BYTE_W-1:0] priority_req_i,
  input  wire logic [BYTE_W-1:0] burst_i,
  input  wire logic [BYTE_W-1:0] process_id_i,
  output logic [BYTE_W-1:0]      ran_id_o,
  output logic [SLOT_W-1:0]      ran_slot_o,
  output logic [TOUT_W-1:0]      time_now_o,
  output logic                   finished_o,
  output logic                   was_idle_o,
  output logic                   all_done_o
);

  logic [BYTE_W-1:0] arr_tab_q [MAX_TASKS];
  logic [BYTE_W-1:0] pri_tab_q [MAX_TASKS];
  logic [BYTE_W-1:0] id_tab_q  [MAX_TASKS];
  logic [BYTE_W-1:0] rem_q     [MAX_TASKS];

  logic [TCNT_W-1:0]    task_cnt_q;
  logic [TIME_BITS-1:0] cur_time_q, cur_time_d;
  logic [CNT_W-1:0]     idx_q;
  logic [CNT_W-1:0]     n_used;

  logic              best_vld_q;
  logic [IDX_W-1:0]  best_slot_q;
  logic [BYTE_W-1:0] best_pri_q, best_arr_q, best_rem_q;
  logic              pend_q;
  logic [IDX_W-1:0]  early_slot_q;
  logic [BYTE_W-1:0] early_pri_q, early_arr_q, early_rem_q;

  logic [IDX_W-1:0]  idx;
  logic [BYTE_W-1:0] s_arr, s_pri, s_rem;
  logic              s_valid, s_ready, upd_best, upd_early;
  logic              load_ok;

  logic [IDX_W-1:0]     sel_slot;
  logic [BYTE_W-1:0]    sel_rem, sel_rem_dec;
  logic [TIME_BITS-1:0] base_time;
  logic                 have_sel;

  assign n_used = (int'(task_cnt_q) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_cnt_q);
  assign sts_o.scan_end = (idx_q >= n_used);

  assign idx   = idx_q[IDX_W-1:0];
  assign s_arr = arr_tab_q[idx];
  assign s_pri = pri_tab_q[idx];
  assign s_rem = rem_q[idx];

  assign s_valid = (s_rem != '0);
  assign s_ready = s_valid && (TIME_BITS'(s_arr) <= cur_time_q);

  assign upd_best = s_ready && (!best_vld_q || (s_pri > best_pri_q) ||
                    ((s_pri == best_pri_q) && (s_arr < best_arr_q)));
  // fallback candidate: earliest pending arrival, highest priority, lowest slot
  assign upd_early = s_valid && (!pend_q || (s_arr < early_arr_q) ||
                     ((s_arr == early_arr_q) && (s_pri > early_pri_q)));

  assign have_sel    = best_vld_q || pend_q;
  assign sel_slot    = best_vld_q ? best_slot_q : early_slot_q;
  assign sel_rem     = best_vld_q ? best_rem_q : early_rem_q;
  assign sel_rem_dec = sel_rem - BYTE_W'(1);
  assign base_time   = best_vld_q ? cur_time_q : TIME_BITS'(early_arr_q);
  assign cur_time_d  = (base_time < TIME_MAX) ? base_time + TIME_BITS'(1) : base_time;

  assign load_ok = (int'(slot_i) < MAX_TASKS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      arr_tab_q[IDX_W'(slot_i)] <= arrival_time_i;
      pri_tab_q[IDX_W'(slot_i)] <= priority_req_i;
      id_tab_q[IDX_W'(slot_i)]  <= process_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        rem_q[i] <= '0;
      end
    end else if (cmd_i.load && load_ok) begin
      rem_q[IDX_W'(slot_i)] <= burst_i;
    end else if (cmd_i.commit && have_sel) begin
      rem_q[sel_slot] <= sel_rem_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_cnt_q <= TASK_CNT_RST;
      cur_time_q <= '0;
      idx_q      <= '0;
      best_vld_q <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        task_cnt_q <= cfg_wdata_i;
      end
      if (cmd_i.scan_start) begin
        idx_q      <= '0;
        best_vld_q <= 1'b0;
        pend_q     <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + CNT_W'(1);
        if (upd_best) begin
          best_vld_q <= 1'b1;
        end
        if (upd_early) begin
          pend_q <= 1'b1;
        end
      end
      if (cmd_i.commit && have_sel) begin
        cur_time_q <= cur_time_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      if (upd_best) begin
        best_slot_q <= idx;
        best_pri_q  <= s_pri;
        best_arr_q  <= s_arr;
        best_rem_q  <= s_rem;
      end
      if (upd_early) begin
        early_slot_q <= idx;
        early_pri_q  <= s_pri;
        early_arr_q  <= s_arr;
        early_rem_q  <= s_rem;
      end
    end
    if (cmd_i.commit) begin
      if (have_sel) begin
        ran_id_o   <= id_tab_q[sel_slot];
        ran_slot_o <= SLOT_W'(sel_slot);
        time_now_o <= TOUT_W'(cur_time_d);
        finished_o <= (sel_rem_dec == '0);
        was_idle_o <= !best_vld_q;
        all_done_o <= 1'b0;
      end else begin
        ran_id_o   <= '0;
        ran_slot_o <= '0;
        time_now_o <= '0;
        finished_o <= 1'b0;
        was_idle_o <= 1'b0;
        all_done_o <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/preemptive_priority_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler - top level
// Input requests either load one task slot or run one time unit. A run
// request returns one result: the task that ran, the time after the unit,
// its finished flag, an idle-jump flag, or all_done when no work remains.
// Load requests are written into the table on acceptance and return nothing.
// A run request steps through S_SCAN once per slot in use, leaves it on
// seeing the end of the scan and passes S_COMMIT, which registers the
// result shown in S_OUT. One request is in flight at a time; in_ready_o
// is high only while idle, so a new request is taken only after the last
// result has been accepted; the single slot comparator scans the slots
// one after another.
// The result is held on the output ports until out_ready_i accepts it; a
// stalled receiver holds off the next request.
// cfg_we_i writes task_count at once and may be used only while idle.
// Reset: task bursts and time clear to zero, task_count returns to 16; the
// other table fields are undefined until a load writes them.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
  import pps_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TCNT_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              kind_i,
  input  wire logic [SLOT_W-1:0] slot_i,
  input  wire logic [BYTE_W-1:0] arrival_time_i,
  input  wire logic [BYTE_W-1:0] priority_req_i,
  input  wire logic [BYTE_W-1:0] burst_i,
  input  wire logic [BYTE_W-1:0] process_id_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [BYTE_W-1:0]      ran_id_o,
  output logic [SLOT_W-1:0]      ran_slot_o,
  output logic [TOUT_W-1:0]      time_now_o,
  output logic                   finished_o,
  output logic                   was_idle_o,
  output logic                   all_done_o
);

  pps_cmd_t cmd;
  pps_sts_t sts;

  pps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pps_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .slot_i         (slot_i),
    .arrival_time_i (arrival_time_i),
    .priority_req_i (priority_req_i),
    .burst_i        (burst_i),
    .process_id_i   (process_id_i),
    .ran_id_o       (ran_id_o),
    .ran_slot_o     (ran_slot_o),
    .time_now_o     (time_now_o),
    .finished_o     (finished_o),
    .was_idle_o     (was_idle_o),
    .all_done_o     (all_done_o)
  );

  a_ready_excl_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is pending");

  a_done_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && all_done_o) |-> (ran_id_o == '0 && ran_slot_o == '0 &&
      time_now_o == '0 && !finished_o && !was_idle_o))
    else $error("all_done result carries nonzero fields");

  a_run_result_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && kind_i == KIND_STEP) |=> !out_valid_o)
    else $error("result shown before scan completed");

endmodule
`default_nettype wire
